/* rtl/sbdc_pkg.sv */
// ----------------------------------------------------------------------------
// sbdc_pkg
// Shared types and constants for the supersample box downscaler.
// ----------------------------------------------------------------------------
package sbdc_pkg;

  localparam int LEVEL_W     = 8;
  localparam int SUM_W       = 14;   // q*q*255 for q up to MAX_BLOCK
  localparam int MAX_BLOCK   = 8;
  localparam int Q_W         = 4;    // holds 0..MAX_BLOCK
  localparam int SUB_W       = 3;    // holds 0..MAX_BLOCK-1
  localparam int RECIP_SHIFT = 20;   // SUM_W + log2(MAX_BLOCK*MAX_BLOCK)
  localparam int RECIP_W     = 21;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int BSIZE_W     = 4;
  localparam int OWIDTH_W    = 9;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_COLOR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR = 2'd3;

  // ceil(2^RECIP_SHIFT / (q*q)), exact floor division for sums below 2^SUM_W
  localparam logic [RECIP_W-1:0] RECIP [0:MAX_BLOCK] = '{
    21'd1048576,  // unused, q is never zero
    21'd1048576,
    21'd262144,
    21'd116509,
    21'd65536,
    21'd41944,
    21'd29128,
    21'd21400,
    21'd16384
  };

  typedef struct packed {
    logic [SUM_W-1:0] bg;
    logic [SUM_W-1:0] ed;
    logic [SUM_W-1:0] fi;
  } sums_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] bg;
    logic [LEVEL_W-1:0] ed;
    logic [LEVEL_W-1:0] fi;
  } avg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] alpha;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } argb_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_COMP
  } state_t;

endpackage

/* rtl/sbdc_ram.sv */
// ----------------------------------------------------------------------------
// sbdc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbdc_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/sbdc_compose.sv */
// ----------------------------------------------------------------------------
// sbdc_compose
// Colour-key compositing of one averaged block into an ARGB pixel.
// ----------------------------------------------------------------------------
module sbdc_compose
  import sbdc_pkg::*;
(
  input  avg_t                  avg,
  input  logic [CFG_DATA_W-1:0] edge_color,
  input  logic [CFG_DATA_W-1:0] fill_color,
  output argb_t                 pixel
);

  function automatic logic [LEVEL_W-1:0] blend(input logic [LEVEL_W-1:0] ec,
                                               input logic [LEVEL_W-1:0] e,
                                               input logic [LEVEL_W-1:0] fc,
                                               input logic [LEVEL_W-1:0] f);
    logic [2*LEVEL_W-1:0] pe;
    logic [2*LEVEL_W-1:0] pf;
    logic [LEVEL_W:0]     s;
    pe = (2*LEVEL_W)'(ec) * (2*LEVEL_W)'(e);
    pf = (2*LEVEL_W)'(fc) * (2*LEVEL_W)'(f);
    s  = {1'b0, pe[2*LEVEL_W-1:LEVEL_W]} + {1'b0, pf[2*LEVEL_W-1:LEVEL_W]};
    return s[LEVEL_W] ? LEVEL_MAX : s[LEVEL_W-1:0];
  endfunction

  argb_t                edge_px;
  argb_t                fill_px;
  logic [2*LEVEL_W-1:0] key_alpha;

  assign edge_px   = argb_t'(edge_color);
  assign fill_px   = argb_t'(fill_color);
  assign key_alpha = (2*LEVEL_W)'(LEVEL_MAX - avg.bg) * (2*LEVEL_W)'(edge_px.alpha);

  always_comb begin
    if (avg.bg != '0) begin
      // background showing: edge colour keyed by remaining coverage
      pixel.alpha = key_alpha[2*LEVEL_W-1:LEVEL_W];
      pixel.red   = edge_px.red;
      pixel.green = edge_px.green;
      pixel.blue  = edge_px.blue;
    end else begin
      pixel.alpha = blend(edge_px.alpha, avg.ed, fill_px.alpha, avg.fi);
      pixel.red   = blend(edge_px.red,   avg.ed, fill_px.red,   avg.fi);
      pixel.green = blend(edge_px.green, avg.ed, fill_px.green, avg.fi);
      pixel.blue  = blend(edge_px.blue,  avg.ed, fill_px.blue,  avg.fi);
    end
  end

endmodule

/* rtl/supersample_box_downscale_colorize.sv */
// ----------------------------------------------------------------------------
// supersample_box_downscale_colorize
// Box-filter downscaler for supersampled coverage pixels with colour keying.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one supersampled pixel per transaction,
//   raster order, each row out_width * block_size pixels long.
// Output channel (out_valid / out_stall): one ARGB pixel per completed
//   block_size x block_size block, emitted on the block's last input pixel.
// Configuration: cfg_write with cfg_index / cfg_data, one register per cycle,
//   only while the block is idle. Writing block_size or out_width restarts
//   the raster at the top left of a block row.
// Pacing: a new input is taken only once the last one is through the
//   read-modify-write of the column accumulator RAM (read, then add and write
//   back) and, if it closes a block, through the reciprocal multiply and the
//   compositing stage.
// Result path: blk_sums, then avg, then the output register with out_valid.
// Reset: raster position cleared, registers back to block_size 1,
//   out_width 256, both colours 0. The accumulator RAM is not cleared; the
//   first pixel of each block overwrites its column entry.
// Stall: a held result sits in the output register; the next input is still
//   taken and summed, and the block only waits if another result is ready.
// ----------------------------------------------------------------------------
module supersample_box_downscale_colorize
  import sbdc_pkg::*;
#(
  parameter int MAX_OUT_WIDTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input pixels
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LEVEL_W-1:0]    bg_level,
  input  logic [LEVEL_W-1:0]    edge_level,
  input  logic [LEVEL_W-1:0]    fill_level,
  // output pixels
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LEVEL_W-1:0]    out_alpha,
  output logic [LEVEL_W-1:0]    out_red,
  output logic [LEVEL_W-1:0]    out_green,
  output logic [LEVEL_W-1:0]    out_blue
);

  localparam int COL_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int CMP_W = (COL_W + 1 > OWIDTH_W) ? COL_W + 1 : OWIDTH_W;
  localparam int RAM_W = 3 * SUM_W;
  localparam int PROD_W = SUM_W + RECIP_W;

  // configuration registers
  logic [BSIZE_W-1:0]    block_size;
  logic [OWIDTH_W-1:0]   out_width;
  logic [CFG_DATA_W-1:0] edge_color;
  logic [CFG_DATA_W-1:0] fill_color;

  // raster position
  logic [COL_W-1:0] out_column;
  logic [SUB_W-1:0] sub_column;
  logic [SUB_W-1:0] sub_row;

  // effective geometry
  logic [Q_W-1:0]   eff_q;
  logic [CMP_W-1:0] eff_w;
  logic [CMP_W-1:0] ow_ext;
  logic [CMP_W-1:0] col_inc;
  logic [Q_W-1:0]   subc_inc;
  logic [Q_W-1:0]   subr_inc;
  logic             col_wrap;
  logic             subc_wrap;
  logic             subr_wrap;

  // item captured at acceptance
  logic [LEVEL_W-1:0] pix_bg;
  logic [LEVEL_W-1:0] pix_ed;
  logic [LEVEL_W-1:0] pix_fi;
  logic [COL_W-1:0]   pix_col;
  logic               pix_first;
  logic               pix_last;

  // accumulator RAM
  logic [RAM_W-1:0] rd_data;
  sums_t            rd_sums;
  sums_t            new_sums;
  sums_t            blk_sums;

  // division and compositing
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod_bg;
  logic [PROD_W-1:0]  prod_ed;
  logic [PROD_W-1:0]  prod_fi;
  avg_t               avg;
  avg_t               avg_next;
  argb_t              pixel;

  // control
  state_t state;
  state_t state_next;
  logic   in_accept;
  logic   ram_wr;
  logic   load_sums;
  logic   load_avg;
  logic   load_out;

  // --------------------------------------------------------------------------
  // Effective geometry: out-of-range values clamp
  // --------------------------------------------------------------------------
  always_comb begin
    if (block_size == '0) begin
      eff_q = Q_W'(1);
    end else if (block_size > BSIZE_W'(MAX_BLOCK)) begin
      eff_q = Q_W'(MAX_BLOCK);
    end else begin
      eff_q = Q_W'(block_size);
    end
  end

  assign ow_ext = CMP_W'(out_width);

  always_comb begin
    if (out_width == '0) begin
      eff_w = CMP_W'(1);
    end else if (ow_ext > CMP_W'(MAX_OUT_WIDTH)) begin
      eff_w = CMP_W'(MAX_OUT_WIDTH);
    end else begin
      eff_w = ow_ext;
    end
  end

  assign col_inc   = CMP_W'(out_column) + CMP_W'(1);
  assign subc_inc  = Q_W'(sub_column) + Q_W'(1);
  assign subr_inc  = Q_W'(sub_row) + Q_W'(1);
  assign col_wrap  = col_inc >= eff_w;
  assign subc_wrap = subc_inc >= eff_q;
  assign subr_wrap = subr_inc >= eff_q;

  assign in_accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Configuration registers and raster position
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BSIZE_W'(1);
      out_width  <= OWIDTH_W'(256);
      edge_color <= '0;
      fill_color <= '0;
      out_column <= '0;
      sub_column <= '0;
      sub_row    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BLOCK_SIZE: begin
          block_size <= cfg_data[BSIZE_W-1:0];
          out_column <= '0;
          sub_column <= '0;
          sub_row    <= '0;
        end
        REG_OUT_WIDTH: begin
          out_width  <= cfg_data[OWIDTH_W-1:0];
          out_column <= '0;
          sub_column <= '0;
          sub_row    <= '0;
        end
        REG_EDGE_COLOR: edge_color <= cfg_data;
        REG_FILL_COLOR: fill_color <= cfg_data;
      endcase
    end else if (in_accept) begin
      if (subc_wrap) begin
        sub_column <= '0;
        if (col_wrap) begin
          out_column <= '0;
          sub_row    <= subr_wrap ? '0 : subr_inc[SUB_W-1:0];
        end else begin
          out_column <= col_inc[COL_W-1:0];
        end
      end else begin
        sub_column <= subc_inc[SUB_W-1:0];
      end
    end
  end

  // capture the accepted pixel; RAM read of its column runs alongside
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pix_bg    <= bg_level;
      pix_ed    <= edge_level;
      pix_fi    <= fill_level;
      pix_col   <= out_column;
      pix_first <= (sub_row == '0) && (sub_column == '0);
      pix_last  <= subr_wrap && subc_wrap;
    end
  end

  // --------------------------------------------------------------------------
  // Column accumulators: read at acceptance, add and write back next cycle
  // --------------------------------------------------------------------------
  sbdc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_OUT_WIDTH)
  ) u_acc_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (pix_col),
    .wr_data (new_sums),
    .rd_en   (in_accept),
    .rd_addr (out_column),
    .rd_data (rd_data)
  );

  assign rd_sums = sums_t'(rd_data);

  always_comb begin
    if (pix_first) begin
      new_sums.bg = SUM_W'(pix_bg);
      new_sums.ed = SUM_W'(pix_ed);
      new_sums.fi = SUM_W'(pix_fi);
    end else begin
      new_sums.bg = rd_sums.bg + SUM_W'(pix_bg);
      new_sums.ed = rd_sums.ed + SUM_W'(pix_ed);
      new_sums.fi = rd_sums.fi + SUM_W'(pix_fi);
    end
  end

  always_ff @(posedge clk) begin
    if (load_sums) begin
      blk_sums <= new_sums;
    end
  end

  // --------------------------------------------------------------------------
  // Divide by q*q through the reciprocal table, saturate to a byte
  // --------------------------------------------------------------------------
  assign recip   = RECIP[eff_q];
  assign prod_bg = PROD_W'(blk_sums.bg) * PROD_W'(recip);
  assign prod_ed = PROD_W'(blk_sums.ed) * PROD_W'(recip);
  assign prod_fi = PROD_W'(blk_sums.fi) * PROD_W'(recip);

  always_comb begin
    avg_next.bg = (|prod_bg[RECIP_SHIFT+LEVEL_W +: SUM_W-LEVEL_W]) ? LEVEL_MAX
                : prod_bg[RECIP_SHIFT +: LEVEL_W];
    avg_next.ed = (|prod_ed[RECIP_SHIFT+LEVEL_W +: SUM_W-LEVEL_W]) ? LEVEL_MAX
                : prod_ed[RECIP_SHIFT +: LEVEL_W];
    avg_next.fi = (|prod_fi[RECIP_SHIFT+LEVEL_W +: SUM_W-LEVEL_W]) ? LEVEL_MAX
                : prod_fi[RECIP_SHIFT +: LEVEL_W];
  end

  always_ff @(posedge clk) begin
    if (load_avg) begin
      avg <= avg_next;
    end
  end

  sbdc_compose u_compose (
    .avg        (avg),
    .edge_color (edge_color),
    .fill_color (fill_color),
    .pixel      (pixel)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_alpha <= pixel.alpha;
      out_red   <= pixel.red;
      out_green <= pixel.green;
      out_blue  <= pixel.blue;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_accept) state_next = ST_ACC;
      ST_ACC:  state_next = pix_last ? ST_DIV : ST_IDLE;
      ST_DIV:  state_next = ST_COMP;
      ST_COMP: if (!out_valid || !out_stall) state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    ram_wr    = 1'b0;
    load_sums = 1'b0;
    load_avg  = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_ACC: begin
        ram_wr    = 1'b1;
        load_sums = pix_last;
      end
      ST_DIV:  load_avg = 1'b1;
      ST_COMP: load_out = !out_valid || !out_stall;
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(out_column) < eff_w)
    else $error("column pointer beyond row width");

  a_sub_in_range: assert property (@(posedge clk) disable iff (rst)
    (Q_W'(sub_column) < eff_q) && (Q_W'(sub_row) < eff_q))
    else $error("sub-block position beyond block size");

  a_div_after_acc: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> $past(state) == ST_ACC && $past(pix_last))
    else $error("divide step without a closing accumulation");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMP && out_valid && out_stall) |=> state == ST_COMP)
    else $error("pending result dropped while output stalled");

  a_accept_to_acc: assert property (@(posedge clk) disable iff (rst)
    in_accept && !cfg_write |=> state == ST_ACC && ram_wr)
    else $error("accepted pixel not written back");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the supersample box downscaler. A scoreboard class
// tracks block sums, raster position and registers, predicts each ARGB pixel
// and checks the output stream in order. Directed cases cover field and
// register extremes, then randomised phases vary geometry, colours, idling
// and output back-pressure.
// ----------------------------------------------------------------------------
class argb_scoreboard;

  localparam int COLUMNS = 256;

  // shadow registers
  logic [sbdc_pkg::BSIZE_W-1:0]    blk_reg;
  logic [sbdc_pkg::OWIDTH_W-1:0]   width_reg;
  logic [sbdc_pkg::CFG_DATA_W-1:0] edge_argb;
  logic [sbdc_pkg::CFG_DATA_W-1:0] fill_argb;

  // per-column block sums and raster position
  int unsigned bg_acc [COLUMNS];
  int unsigned ed_acc [COLUMNS];
  int unsigned fi_acc [COLUMNS];
  int unsigned column;
  int unsigned sub_col;
  int unsigned sub_row;

  sbdc_pkg::argb_t pending_argb [$];
  int mismatches;
  int pixels_checked;

  function new();
    blk_reg        = 1;
    width_reg      = 256;
    edge_argb      = '0;
    fill_argb      = '0;
    column         = 0;
    sub_col        = 0;
    sub_row        = 0;
    mismatches     = 0;
    pixels_checked = 0;
  endfunction

  function int unsigned eff_block();
    if (blk_reg == 0) return 1;
    if (blk_reg > sbdc_pkg::MAX_BLOCK) return sbdc_pkg::MAX_BLOCK;
    return blk_reg;
  endfunction

  function int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > COLUMNS) return COLUMNS;
    return width_reg;
  endfunction

  function int pending();
    return pending_argb.size();
  endfunction

  function void write_reg(logic [sbdc_pkg::CFG_IDX_W-1:0] idx,
                          logic [sbdc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      sbdc_pkg::REG_BLOCK_SIZE: begin
        blk_reg = data[sbdc_pkg::BSIZE_W-1:0];
        column = 0; sub_col = 0; sub_row = 0;
      end
      sbdc_pkg::REG_OUT_WIDTH: begin
        width_reg = data[sbdc_pkg::OWIDTH_W-1:0];
        column = 0; sub_col = 0; sub_row = 0;
      end
      sbdc_pkg::REG_EDGE_COLOR: edge_argb = data;
      sbdc_pkg::REG_FILL_COLOR: fill_argb = data;
      default: ;
    endcase
  endfunction

  function int unsigned sat8(int unsigned v);
    return (v > sbdc_pkg::LEVEL_MAX) ? sbdc_pkg::LEVEL_MAX : v;
  endfunction

  // weighted mix of one channel of the two colours
  function logic [7:0] blend(int sh, int unsigned e, int unsigned f);
    int unsigned ec;
    int unsigned fc;
    ec = (edge_argb >> sh) & 32'hFF;
    fc = (fill_argb >> sh) & 32'hFF;
    return 8'(sat8(((ec * e) >> 8) + ((fc * f) >> 8)));
  endfunction

  function void accumulate_pixel(logic [7:0] bg, logic [7:0] ed, logic [7:0] fi);
    int unsigned q;
    int unsigned w;
    int unsigned c;
    int unsigned qq;
    int unsigned avg_bg;
    int unsigned avg_ed;
    int unsigned avg_fi;
    sbdc_pkg::argb_t px;
    q = eff_block();
    w = eff_width();
    c = column % COLUMNS;
    // top-left pixel of a block starts the column sum afresh
    if (sub_row == 0 && sub_col == 0) begin
      bg_acc[c] = bg;
      ed_acc[c] = ed;
      fi_acc[c] = fi;
    end else begin
      bg_acc[c] += bg;
      ed_acc[c] += ed;
      fi_acc[c] += fi;
    end
    if (sub_row + 1 >= q && sub_col + 1 >= q) begin
      qq     = q * q;
      avg_bg = sat8(bg_acc[c] / qq);
      avg_ed = sat8(ed_acc[c] / qq);
      avg_fi = sat8(fi_acc[c] / qq);
      if (avg_bg != 0) begin
        px.alpha = 8'(((sbdc_pkg::LEVEL_MAX - avg_bg) * edge_argb[31:24]) >> 8);
        px.red   = edge_argb[23:16];
        px.green = edge_argb[15:8];
        px.blue  = edge_argb[7:0];
      end else begin
        px.alpha = blend(24, avg_ed, avg_fi);
        px.red   = blend(16, avg_ed, avg_fi);
        px.green = blend(8, avg_ed, avg_fi);
        px.blue  = blend(0, avg_ed, avg_fi);
      end
      pending_argb.push_back(px);
    end
    sub_col++;
    if (sub_col >= q) begin
      sub_col = 0;
      column++;
      if (column >= w) begin
        column = 0;
        sub_row++;
        if (sub_row >= q) sub_row = 0;
      end
    end
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch: %s", msg);
  endtask

  task compare_channel(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("pixel %0d %s got %02h want %02h",
                                pixels_checked, name, got, want));
  endtask

  task check_argb(logic [7:0] a, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    sbdc_pkg::argb_t want;
    if (pending_argb.size() == 0) begin
      report_mismatch($sformatf("unexpected pixel %02h%02h%02h%02h", a, r, g, b));
      return;
    end
    want = pending_argb.pop_front();
    compare_channel("alpha", a, want.alpha);
    compare_channel("red", r, want.red);
    compare_channel("green", g, want.green);
    compare_channel("blue", b, want.blue);
    pixels_checked++;
  endtask

endclass

module testbench;
  import sbdc_pkg::*;

  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_ITEMS  = 550;

  localparam logic [3:0] SET_BSIZE    = 4'b1 << REG_BLOCK_SIZE;
  localparam logic [3:0] SET_GEOMETRY = SET_BSIZE | (4'b1 << REG_OUT_WIDTH);
  localparam logic [3:0] SET_EDGE     = 4'b1 << REG_EDGE_COLOR;
  localparam logic [3:0] SET_COLOURS  = SET_EDGE | (4'b1 << REG_FILL_COLOR);
  localparam logic [3:0] SET_ALL      = SET_GEOMETRY | SET_COLOURS;

  typedef enum {BG_CLEAR, BG_ANY, BG_SPARSE} bg_style_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [LEVEL_W-1:0]    bg_level;
  logic [LEVEL_W-1:0]    edge_level;
  logic [LEVEL_W-1:0]    fill_level;
  logic                  out_valid;
  logic                  out_stall;
  logic [LEVEL_W-1:0]    out_alpha;
  logic [LEVEL_W-1:0]    out_red;
  logic [LEVEL_W-1:0]    out_green;
  logic [LEVEL_W-1:0]    out_blue;

  // idling percentages, changed per phase
  int send_idle_pct;
  int stall_pct;
  logic hold_off;
  event hold_kick;

  argb_scoreboard sb;

  supersample_box_downscale_colorize dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .bg_level   (bg_level),
    .edge_level (edge_level),
    .fill_level (fill_level),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_alpha  (out_alpha),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop, well beyond the slowest legal run
  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

  // Long receiver hold-off, counted here so the sender keeps offering
  // transactions and the block backs up onto in_stall
  initial begin
    hold_off = 1'b0;
    forever begin
      @(hold_kick);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  // Receiver: random stall on top of any hold-off
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
  end

  // Monitors: both sides sampled at the edge where the transaction happens
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.accumulate_pixel(bg_level, edge_level, fill_level);
    if (!rst && out_valid && !out_stall)
      sb.check_argb(out_alpha, out_red, out_green, out_blue);
  end

  // Offer one pixel; the idle decision is made before valid rises
  task automatic send_pixel(input logic [7:0] bg, input logic [7:0] ed,
                            input logic [7:0] fi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    bg_level   <= bg;
    edge_level <= ed;
    fill_level <= fi;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Back-to-back register writes, one per cycle; block must be idle
  task automatic reconfigure(input logic [3:0] mask, input logic [31:0] bs,
                             input logic [31:0] ow, input logic [31:0] ec,
                             input logic [31:0] fc);
    if (mask[REG_BLOCK_SIZE]) put_reg(REG_BLOCK_SIZE, bs);
    if (mask[REG_OUT_WIDTH])  put_reg(REG_OUT_WIDTH, ow);
    if (mask[REG_EDGE_COLOR]) put_reg(REG_EDGE_COLOR, ec);
    if (mask[REG_FILL_COLOR]) put_reg(REG_FILL_COLOR, fc);
    cfg_write <= 1'b0;
  endtask

  // Drop valid, drain every expected pixel, then allow for a transaction
  // still in flight that closes no block
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return LEVEL_MAX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] rand_colour();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          phase;
    int          random_items;
    int unsigned row_len;
    int unsigned n;
    int unsigned pick;
    logic [31:0] bs;
    logic [31:0] ow;
    logic [3:0]  mask;
    logic [7:0]  bg;
    bit          pressure;
    bg_style_t   bg_style;

    sb            = new();
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_BLOCK_SIZE;
    cfg_data      = '0;
    in_valid      = 1'b0;
    bg_level      = '0;
    edge_level    = '0;
    fill_level    = '0;
    out_stall     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // --- directed ----------------------------------------------------------
    // q = 1, white on white: blend saturates, plain zero, full and
    // minimal background
    reconfigure(SET_ALL, 1, 4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(8'h00, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h01, 8'h80, 8'h40);
    settle();

    // q = 2, width 0 acts as 1; background sum floors to zero average
    reconfigure(SET_ALL, 2, 0, 32'h80C0_4020, 32'h7F3F_1FE0);
    send_pixel(8'h01, 8'd200, 8'd10);
    send_pixel(8'h01, 8'd100, 8'd20);
    send_pixel(8'h01, 8'd50, 8'd30);
    send_pixel(8'h00, 8'd0, 8'd40);
    settle();

    // block size 0 acts as 1
    reconfigure(SET_GEOMETRY, 0, 2, 0, 0);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'hFF, 8'h00);
    settle();

    // oversize block left part-filled, then geometry rewritten mid-block
    reconfigure(SET_GEOMETRY, 15, 1, 0, 0);
    send_pixel(8'h00, 8'h01, 8'h02);
    send_pixel(8'h55, 8'hAA, 8'h55);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    settle();
    // junk above the block size field, width beyond the maximum
    reconfigure(SET_GEOMETRY, 32'hFFFF_FFF1, 511, 0, 0);
    send_pixel(8'h00, 8'h7F, 8'h80);
    send_pixel(8'h80, 8'h01, 8'hFE);
    send_pixel(8'h00, 8'hFE, 8'h01);
    settle();

    // colour swapped halfway through a block
    reconfigure(SET_GEOMETRY, 2, 1, 0, 0);
    send_pixel(8'h00, 8'hC0, 8'h30);
    send_pixel(8'h00, 8'h40, 8'h90);
    settle();
    reconfigure(SET_EDGE, 0, 0, 32'hFF00_FF00, 0);
    send_pixel(8'h00, 8'hF0, 8'h0F);
    send_pixel(8'h00, 8'h10, 8'hE1);
    settle();

    // --- random phases -----------------------------------------------------
    phase        = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      pressure = (phase % 6 == 1);
      case (phase % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 55; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 55; end
        default: begin send_idle_pct = 8;  stall_pct = 8;  end
      endcase
      if (pressure) send_idle_pct = 0;

      pick = $urandom_range(0, 11);
      if (pressure) begin
        bs = 1;
        ow = $urandom_range(1, 8);
      end else if (pick == 0) begin
        // wide rows only at q = 1 so every column closes quickly
        bs = $urandom_range(0, 1);
        ow = $urandom_range(256, 511);
      end else if (pick == 1) begin
        bs = $urandom_range(8, 15);
        ow = $urandom_range(0, 1);
      end else begin
        bs = $urandom_range(1, 4);
        ow = $urandom_range(0, 6);
      end
      if ($urandom_range(0, 3) == 0) begin
        bs = bs | ($urandom & 32'hFFFF_FFF0);
        ow = ow | ($urandom & 32'hFFFF_FE00);
      end

      // leaving geometry alone carries on from wherever the raster stopped
      mask = '0;
      if (pressure || $urandom_range(0, 2) != 0) mask = mask | SET_GEOMETRY;
      if ($urandom_range(0, 1) == 0)             mask = mask | SET_COLOURS;
      if (mask != 0) reconfigure(mask, bs, ow, rand_colour(), rand_colour());

      row_len = sb.eff_block() * sb.eff_block() * sb.eff_width();
      if (pressure)
        n = 80;
      else if ($urandom_range(0, 4) == 0)
        n = $urandom_range(1, 40);   // stop part-way through a block
      else
        n = (row_len >= 64) ? row_len : row_len * (64 / row_len);
      if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;

      bg_style = bg_style_t'($urandom_range(0, 2));
      if (pressure) ->hold_kick;
      for (int k = 0; k < n; k++) begin
        case (bg_style)
          BG_CLEAR: bg = 8'h00;
          BG_ANY:   bg = 8'($urandom_range(0, 255));
          default:  bg = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 3)) : 8'h00;
        endcase
        send_pixel(bg, rand_level(), rand_level());
      end
      random_items += n;
      settle();
      phase++;
    end

    // --- wind down ---------------------------------------------------------
    send_idle_pct = 0;
    stall_pct     = 0;
    settle();
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d pixels never came out", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sbdc_pkg.sv
rtl/sbdc_ram.sv
rtl/sbdc_compose.sv
rtl/supersample_box_downscale_colorize.sv
tb/testbench.sv
